// ----- rtl/bc1_block_decoder_assert.svh -----
// Assertion macros for the BC1 block decoder.
// Expects clk and rst in the scope of the module that uses them.
`ifndef BC1_BLOCK_DECODER_ASSERT_SVH
`define BC1_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BC1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BC1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bc1_pkg.sv -----
// Shared types, constants and channel math for the BC1 block decoder.
// No dependencies.
`default_nettype none

package bc1_pkg;

  localparam int COORD_W      = 12;
  localparam int CHAN_W       = 8;
  localparam int BLOCK_DIM    = 4;
  localparam int BLOCK_PIXELS = BLOCK_DIM * BLOCK_DIM;
  localparam int WIDTH_W      = 13;
  localparam int COORD_LIMIT  = 4096;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd256;
  localparam logic [15:0]        GREEN_MASK        = 16'h07E0;
  localparam logic [15:0]        BLUE_MASK         = 16'h001F;
  localparam logic [7:0]         CHAN_SCALE        = 8'd255;
  localparam logic [1:0]         INDEX_MASK        = 2'h3;
  localparam logic [9:0]         THIRD_RECIP       = 10'd683;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef rgb_t [3:0] palette_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    rgb_t               color;
    logic               block_done;
  } pixel_t;

  // ((v*255 + n/2)/n + (v*255 + n/2))/n with n = 32 or 64
  function automatic logic [CHAN_W-1:0] expand_chan(input logic [5:0] v, input logic wide);
    logic [13:0] t;
    logic [14:0] s;
    logic [14:0] e;
    t = 14'(v) * 14'(CHAN_SCALE) + (wide ? 14'd32 : 14'd16);
    s = 15'(wide ? (t >> 6) : (t >> 5)) + 15'(t);
    e = wide ? (s >> 6) : (s >> 5);
    return e[CHAN_W-1:0];
  endfunction

  // floor(x/3) for x < 768, x*683 >> 11
  function automatic logic [CHAN_W-1:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(THIRD_RECIP);
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bc1_palette.sv -----
// Endpoint expansion and four-entry palette build for one BC1 block.
// Depends on bc1_pkg.
`default_nettype none

module bc1_palette (
  input  wire logic [15:0]       color0,
  input  wire logic [15:0]       color1,
  output bc1_pkg::palette_t      palette
);

  bc1_pkg::rgb_t c0;
  bc1_pkg::rgb_t c1;
  logic          four;

  assign c0.red   = bc1_pkg::expand_chan({1'b0, color0[15:11]}, 1'b0);
  assign c0.green = bc1_pkg::expand_chan(6'((color0 & bc1_pkg::GREEN_MASK) >> 5), 1'b1);
  assign c0.blue  = bc1_pkg::expand_chan({1'b0, color0[4:0] & bc1_pkg::BLUE_MASK[4:0]}, 1'b0);
  assign c1.red   = bc1_pkg::expand_chan({1'b0, color1[15:11]}, 1'b0);
  assign c1.green = bc1_pkg::expand_chan(6'((color1 & bc1_pkg::GREEN_MASK) >> 5), 1'b1);
  assign c1.blue  = bc1_pkg::expand_chan({1'b0, color1[4:0] & bc1_pkg::BLUE_MASK[4:0]}, 1'b0);

  assign four = color0 > color1;

  function automatic logic [7:0] mix2(input logic [7:0] a, input logic [7:0] b, input logic f);
    logic [9:0] s;
    logic [8:0] m;
    s = {1'b0, a, 1'b0} + {2'b00, b};
    m = {1'b0, a} + {1'b0, b};
    return f ? bc1_pkg::div3(s) : m[8:1];
  endfunction

  always_comb begin
    palette[0]       = c0;
    palette[1]       = c1;
    palette[2].red   = mix2(c0.red,   c1.red,   four);
    palette[2].green = mix2(c0.green, c1.green, four);
    palette[2].blue  = mix2(c0.blue,  c1.blue,  four);
    palette[3].red   = four ? mix2(c1.red,   c0.red,   1'b1) : '0;
    palette[3].green = four ? mix2(c1.green, c0.green, 1'b1) : '0;
    palette[3].blue  = four ? mix2(c1.blue,  c0.blue,  1'b1) : '0;
  end

endmodule

`default_nettype wire

// ----- rtl/bc1_cell.sv -----
// One pixel cell of the output chain: loads its own pixel from the palette
// and shifts its neighbor's pixel toward the head. Depends on bc1_pkg.
`default_nettype none

module bc1_cell #(
  parameter int COL_OFS = 0,
  parameter int ROW_OFS = 0,
  parameter bit LAST    = 1'b0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic                        advance,
  input  wire bc1_pkg::palette_t           palette,
  input  wire logic [1:0]                  idx,
  input  wire logic [bc1_pkg::COORD_W-1:0] base_x,
  input  wire logic [bc1_pkg::COORD_W-1:0] base_y,
  input  wire bc1_pkg::pixel_t             up_px,
  input  wire logic                        up_valid,
  output bc1_pkg::pixel_t                  px,
  output logic                             valid
);

  bc1_pkg::pixel_t own;

  always_comb begin
    own.pixel_x    = base_x + bc1_pkg::COORD_W'(COL_OFS);
    own.pixel_y    = base_y + bc1_pkg::COORD_W'(ROW_OFS);
    own.color      = palette[idx & bc1_pkg::INDEX_MASK];
    own.block_done = LAST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px <= own;
    end else if (advance) begin
      px <= up_px;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bc1_block_decoder.sv -----
// BC1 block decoder: one 64-bit block in, 16 pixels out, one per cycle unless stalled.
// First pixel: registered in the buffer, then in cell 0 when the chain is empty.
// Throughput: one pixel per cycle from the 16-cell chain while m_tready is high;
// the next block is held in a one-entry buffer and loads as the last pixel leaves.
// Reset: synchronous; clears the chain, buffer, block position, width to 256.
// Depends on bc1_pkg, bc1_palette, bc1_cell, bc1_block_decoder_assert.svh.
`default_nettype none
`include "bc1_block_decoder_assert.svh"

module bc1_block_decoder #(
  parameter int MAX_IMAGE_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // block requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // color0[15:0], color1[31:16], index_bits[63:32]
  input  wire logic        s_tuser,   // first_block
  // pixels
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // pixel_x[11:0], pixel_y[23:12], red, green, blue
  output logic             m_tlast    // block_done
);

  localparam int WIDTH_CAP = (MAX_IMAGE_WIDTH < bc1_pkg::COORD_LIMIT) ?
                             MAX_IMAGE_WIDTH : bc1_pkg::COORD_LIMIT;
  localparam int NCELL = bc1_pkg::BLOCK_PIXELS;

  logic [bc1_pkg::WIDTH_W-1:0] image_width;
  logic [bc1_pkg::WIDTH_W-1:0] eff_width;
  logic                        cfg_wr;

  logic [bc1_pkg::COORD_W-1:0] block_column, block_column_next;
  logic [bc1_pkg::COORD_W-1:0] block_row, block_row_next;
  logic [bc1_pkg::COORD_W-1:0] base_col, base_row;

  logic                        hold_valid;
  logic [15:0]                 hold_c0, hold_c1;
  logic [31:0]                 hold_index;
  logic [bc1_pkg::COORD_W-1:0] hold_col, hold_row;

  logic                        accept;
  logic                        advance;
  logic                        load_go;
  bc1_pkg::palette_t           palette;

  bc1_pkg::pixel_t             cpx [NCELL+1];
  logic [NCELL:0]              cv;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {19'd0, image_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bc1_pkg::IMAGE_WIDTH_RESET;
    end else if (cfg_wr) begin
      image_width <= pwdata[bc1_pkg::WIDTH_W-1:0];
    end
  end

  assign eff_width = (image_width > bc1_pkg::WIDTH_W'(WIDTH_CAP)) ?
                     bc1_pkg::WIDTH_W'(WIDTH_CAP) : image_width;

  // chain control
  assign advance  = ~cv[0] | m_tready;
  assign load_go  = advance & ~cv[1] & hold_valid;
  assign s_tready = ~hold_valid | load_go;
  assign accept   = s_tvalid & s_tready;

  // block position
  always_comb begin
    base_col = s_tuser ? '0 : block_column;
    base_row = s_tuser ? '0 : block_row;
    if (({1'b0, base_col} + 13'd4) >= eff_width) begin
      block_column_next = '0;
      block_row_next    = base_row + 12'd4;
    end else begin
      block_column_next = base_col + 12'd4;
      block_row_next    = base_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
      hold_valid   <= 1'b0;
    end else begin
      if (accept) begin
        block_column <= block_column_next;
        block_row    <= block_row_next;
      end
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (load_go) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_c0    <= s_tdata[15:0];
      hold_c1    <= s_tdata[31:16];
      hold_index <= s_tdata[63:32];
      hold_col   <= base_col;
      hold_row   <= base_row;
    end
  end

  bc1_palette u_palette (
    .color0  (hold_c0),
    .color1  (hold_c1),
    .palette (palette)
  );

  // pixel chain, cell 0 is the output register
  assign cpx[NCELL] = '0;
  assign cv[NCELL]  = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    bc1_cell #(
      .COL_OFS (i % bc1_pkg::BLOCK_DIM),
      .ROW_OFS (i / bc1_pkg::BLOCK_DIM),
      .LAST    (i == NCELL - 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (load_go),
      .advance  (advance),
      .palette  (palette),
      .idx      (hold_index[2*i +: 2]),
      .base_x   (hold_col),
      .base_y   (hold_row),
      .up_px    (cpx[i+1]),
      .up_valid (cv[i+1]),
      .px       (cpx[i]),
      .valid    (cv[i])
    );
  end

  assign m_tvalid = cv[0];
  assign m_tlast  = cpx[0].block_done;
  assign m_tdata  = {cpx[0].color.blue, cpx[0].color.green, cpx[0].color.red,
                     cpx[0].pixel_y, cpx[0].pixel_x};

  `BC1_ASSERT_NOW(a_last_empties_chain, m_tvalid && m_tlast, !cv[1],
                  "pixels behind the last pixel of a block")
  `BC1_ASSERT_NEXT(a_load_shows_pixel, load_go, m_tvalid && !m_tlast,
                   "loaded block did not present its first pixel")
  `BC1_ASSERT_NEXT(a_hold_kept, hold_valid && !load_go, hold_valid,
                   "buffered block lost before loading")

endmodule

`default_nettype wire

// ----- tb/bc1_checker.sv -----
`timescale 1ns / 100ps
// Pixel checker for bc1_block_decoder: follows APB width writes and block requests,
// predicts the 16 decoded pixels of every block and compares the pixel stream in order.
// Depends on bc1_pkg for the pixel and color types.
module bc1_checker
  import bc1_pkg::*;
#(
  parameter int         MAX_IMAGE_WIDTH = 4096,
  parameter logic [2:0] WIDTH_ADDR      = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // color0, color1, index_bits
  input  logic        s_tuser,   // first_block
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // pixel_x, pixel_y, red, green, blue
  input  logic        m_tlast,   // block_done
  output int          fail_count,
  output int          pending,
  output int          blocks_in,
  output int          pixels_out
);

  pixel_t             pixel_q[$];
  logic [WIDTH_W-1:0] img_width;
  logic [COORD_W-1:0] blk_col;
  logic [COORD_W-1:0] blk_row;

  function automatic logic [CHAN_W-1:0] widen(input int unsigned v, input int unsigned n);
    int unsigned t;
    t = v * 255 + n / 2;
    return CHAN_W'((t / n + t) / n);
  endfunction

  function automatic rgb_t unpack565(input logic [15:0] c);
    rgb_t e;
    e.red   = widen(c[15:11], 32);
    e.green = widen(c[10:5], 64);
    e.blue  = widen(c[4:0], 32);
    return e;
  endfunction

  function automatic rgb_t blend(input rgb_t a, input rgb_t b, input int unsigned wa,
                                 input int unsigned wb, input int unsigned dv);
    rgb_t m;
    m.red   = CHAN_W'((wa * a.red + wb * b.red) / dv);
    m.green = CHAN_W'((wa * a.green + wb * b.green) / dv);
    m.blue  = CHAN_W'((wa * a.blue + wb * b.blue) / dv);
    return m;
  endfunction

  task automatic decode_block(input logic first, input logic [15:0] c0, input logic [15:0] c1,
                              input logic [31:0] idx);
    rgb_t        pal [4];
    pixel_t      px;
    int unsigned eff;
    if (first) begin
      blk_col = '0;
      blk_row = '0;
    end
    pal[0] = unpack565(c0);
    pal[1] = unpack565(c1);
    if (c0 > c1) begin
      pal[2] = blend(pal[0], pal[1], 2, 1, 3);
      pal[3] = blend(pal[0], pal[1], 1, 2, 3);
    end else begin
      pal[2] = blend(pal[0], pal[1], 1, 1, 2);
      pal[3] = '0;
    end
    for (int p = 0; p < BLOCK_PIXELS; p++) begin
      px.pixel_x    = blk_col + COORD_W'(p % BLOCK_DIM);
      px.pixel_y    = blk_row + COORD_W'(p / BLOCK_DIM);
      px.color      = pal[idx[2*p +: 2]];
      px.block_done = (p == BLOCK_PIXELS - 1);
      pixel_q.push_back(px);
    end
    eff = img_width;
    if (eff > MAX_IMAGE_WIDTH) eff = MAX_IMAGE_WIDTH;
    if (eff > COORD_LIMIT) eff = COORD_LIMIT;
    if (int'(blk_col) + BLOCK_DIM >= eff) begin
      blk_col = '0;
      blk_row = blk_row + COORD_W'(BLOCK_DIM);
    end else begin
      blk_col = blk_col + COORD_W'(BLOCK_DIM);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pixel_q.delete();
      img_width  = IMAGE_WIDTH_RESET;
      blk_col    = '0;
      blk_row    = '0;
      fail_count = 0;
      blocks_in  = 0;
      pixels_out = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel with no block pending: x=%0d y=%0d", m_tdata[11:0], m_tdata[23:12]);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", want.pixel_x, m_tdata[11:0]);
          check_field("pixel_y", want.pixel_y, m_tdata[23:12]);
          check_field("red", want.color.red, m_tdata[31:24]);
          check_field("green", want.color.green, m_tdata[39:32]);
          check_field("blue", want.color.blue, m_tdata[47:40]);
          check_field("block_done", want.block_done, m_tlast);
          pixels_out++;
        end
      end
      if (psel && penable && pready && paddr == WIDTH_ADDR) begin
        if (pwrite) img_width = pwdata[WIDTH_W-1:0];
        else check_field("image_width", 32'(img_width), prdata);
      end
      if (s_tvalid && s_tready) begin
        decode_block(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]);
        blocks_in++;
      end
    end
    pending <= pixel_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the bc1_block_decoder testbench: clock, reset, APB width setup, block requests
// and pixel back-pressure; bc1_checker does prediction and comparison.
// Depends on bc1_pkg, bc1_block_decoder and bc1_checker.
module tb;
  import bc1_pkg::*;

  localparam int         MAX_W       = 4096;
  localparam logic [2:0] WIDTH_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR  = 3'd4;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         BATCH_ITEMS = 41;
  localparam int         SWEEP_ITEMS = 40;
  localparam int         NUM_BATCH   = 9;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  int fail_count, pending, blocks_in, pixels_out;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cnt   = 0;
  int settings    = 0;
  bit hold_req    = 1'b0;

  always #1 clk = ~clk;

  bc1_block_decoder #(.MAX_IMAGE_WIDTH(MAX_W)) DUT (.*);

  bc1_checker #(.MAX_IMAGE_WIDTH(MAX_W), .WIDTH_ADDR(WIDTH_ADDR)) u_checker (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending), .blocks_in(blocks_in),
    .pixels_out(pixels_out)
  );

  // pixel side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d pixels pending", stall_cnt, pending);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_block(input logic first, input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {idx, c1, c0};
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_block(input bit may_restart);
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] idx;
    c0 = 16'($urandom);
    c1 = 16'($urandom);
    case ($urandom_range(5))
      1: c1 = c0;
      2: if (c0 < c1) {c0, c1} = {c1, c0};
      3: if (c0 > c1) {c0, c1} = {c1, c0};
      4: begin
        c0 = {16{1'($urandom)}};
        c1 = {16{1'($urandom)}};
      end
      5: c1 = $urandom_range(1) ? c0 + 16'd1 : c0 - 16'd1;
      default: ;
    endcase
    idx = $urandom;
    if ($urandom_range(9) == 0) idx = {32{1'($urandom)}};
    push_block(may_restart && ($urandom_range(19) == 0), c0, c1, idx);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    drain();
    apb_access(1'b1, WIDTH_ADDR, {19'($urandom), w});
    apb_access(1'b0, WIDTH_ADDR, '0);
    settings++;
  endtask

  initial begin
    logic [WIDTH_W-1:0] widths [NUM_BATCH];
    widths = '{13'd4, 13'd4096, 13'd8191, 13'd0, 13'd6, 13'd13, 13'd64, 13'd4092, 13'd100};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: endpoint extremes, both color modes, every index
    tx_idle_pct = 18;
    rx_idle_pct = 51;
    apb_access(1'b0, WIDTH_ADDR, '0);
    push_block(1'b1, 16'hFFFF, 16'h0000, 32'h0000_0000);
    push_block(1'b0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    push_block(1'b0, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
    push_block(1'b0, 16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
    push_block(1'b0, 16'h0000, 16'h0000, 32'h1B1B_1B1B);
    push_block(1'b0, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);
    push_block(1'b0, 16'hF800, 16'h07E0, 32'hE4E4_E4E4);
    push_block(1'b0, 16'h001F, 16'hF800, 32'h4E4E_4E4E);
    push_block(1'b0, 16'h8000, 16'h7FFF, 32'hE4E4_E4E4);
    push_block(1'b0, 16'h7BEF, 16'h7BEF, 32'h5555_5555);
    push_block(1'b0, 16'h0001, 16'h0000, 32'hE4E4_E4E4);
    push_block(1'b0, 16'h0000, 16'h0001, 32'hE4E4_E4E4);
    push_block(1'b1, 16'h1234, 16'h5678, 32'h0123_4567);
    push_block(1'b0, 16'hFFE0, 16'h001F, 32'h89AB_CDEF);
    set_width(13'd6);
    push_block(1'b0, 16'h07E0, 16'hF81F, 32'hE4E4_E4E4);
    push_block(1'b0, 16'hF81F, 16'h07E0, 32'h1B1B_1B1B);
    push_block(1'b0, 16'hAAAA, 16'h5555, 32'h3210_CDEF);
    set_width(13'd0);
    push_block(1'b0, 16'h5555, 16'hAAAA, 32'hE4E4_E4E4);
    push_block(1'b0, 16'hC0DE, 16'hC0DE, 32'hFFFF_0000);
    drain();
    apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF);
    push_block(1'b0, 16'h4321, 16'h1234, 32'h0000_FFFF);

    // random phases, one width each; idle pattern changes every three phases
    for (int b = 0; b < NUM_BATCH; b++) begin
      case (b / 3)
        0: begin tx_idle_pct = 18; rx_idle_pct = 51; end
        1: begin tx_idle_pct = 51; rx_idle_pct = 18; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      set_width(widths[b]);
      push_block(1'b1, 16'($urandom), 16'($urandom), $urandom);
      for (int i = 0; i < BATCH_ITEMS; i++) begin
        if (b == 4 && i == 10) hold_req = 1'b1;
        if (b == 1 && i == 25) drain();
        random_block(1'b1);
      end
    end

    // back-to-back runs at the widest clamped width, then at width 4
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_width(13'd8191);
    push_block(1'b1, 16'($urandom), 16'($urandom), $urandom);
    for (int i = 0; i < SWEEP_ITEMS; i++) random_block(1'b0);
    set_width(13'd4);
    push_block(1'b1, 16'($urandom), 16'($urandom), $urandom);
    for (int i = 0; i < SWEEP_ITEMS; i++) random_block(1'b0);

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d blocks, %0d pixels checked, %0d width writes incl. 0, 8191, odd sizes;",
             blocks_in, pixels_out, settings);
    $display("both color modes, all indices, restarts, long stalls, %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
